// ===== hdl/bitn_pkg.sv =====
// Shared constants, codes and types of the binary image thinning block.
// No dependencies; every other file of the block but bitn_ram refers to this package.
`timescale 1ns / 1ps

package bitn_pkg;

    // Image store geometry
    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 1024;
    localparam int WORD_W   = 32;
    localparam int WORDS    = MAX_COLS / WORD_W;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int WIDX_W   = COL_W - BIT_W;
    localparam int ADDR_W   = ROW_W + WIDX_W;

    // Field and register widths
    localparam int NR_W       = 9;
    localparam int NC_W       = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int MODE_W     = 2;
    localparam int RND_W      = 16;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIX_RD,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        SIDE_N,
        SIDE_S,
        SIDE_E,
        SIDE_W
    } side_t;

    // Three consecutive words of one image row
    typedef struct packed {
        logic [WORD_W-1:0] nxt;
        logic [WORD_W-1:0] cur;
        logic [WORD_W-1:0] prv;
    } line_t;

    // Position and settings for the deletion kernel
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [WIDX_W-1:0] word;
        side_t             side;
        logic [NR_W-1:0]   nr;
        logic [NC_W-1:0]   nc;
    } kern_ctl_t;

endpackage

// ===== hdl/bitn_if.sv =====
// Valid/ready channel interfaces for the thinning block input and result beats.
// Depends on bitn_pkg.
`timescale 1ns / 1ps

interface bitn_in_if;
    logic                        valid;
    logic                        ready;
    logic [bitn_pkg::MODE_W-1:0] mode;
    logic [bitn_pkg::ROW_W-1:0]  row;
    logic [bitn_pkg::COL_W-1:0]  col;
    logic                        pixel;

    modport source (output valid, output mode, output row, output col, output pixel,
                    input ready);
    modport sink   (input valid, input mode, input row, input col, input pixel,
                    output ready);
endinterface

interface bitn_out_if;
    logic                       valid;
    logic                       ready;
    logic                       read_pixel;
    logic [bitn_pkg::RND_W-1:0] round_count;

    modport source (output valid, output read_pixel, output round_count, input ready);
    modport sink   (input valid, input read_pixel, input round_count, output ready);
endinterface

// ===== hdl/bitn_ram.sv =====
// Generic single-port-write, single-port-read RAM with bit write enables.
// Registered read data. No dependencies.
`timescale 1ns / 1ps

module bitn_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 13
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [DATA_W-1:0] wmask,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int i = 0; i < DATA_W; i++)
            begin
                if (wmask[i])
                begin
                    mem[waddr][i] <= wdata[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/bitn_kernel.sv =====
// Per-word deletion logic of one thinning sub-pass: 32 pixels at once from a
// 3x3-word window of the old image. Depends on bitn_pkg.
`timescale 1ns / 1ps

module bitn_kernel (
    input  bitn_pkg::kern_ctl_t          ctl,
    input  bitn_pkg::line_t              up,
    input  bitn_pkg::line_t              mid,
    input  bitn_pkg::line_t              dn,
    output logic [bitn_pkg::WORD_W-1:0]  new_word,
    output logic                         any_del
);

    always_comb
    begin
        logic [bitn_pkg::WORD_W+1:0] ue;
        logic [bitn_pkg::WORD_W+1:0] me;
        logic [bitn_pkg::WORD_W+1:0] de;
        logic [bitn_pkg::WORD_W-1:0] del;
        logic [bitn_pkg::COL_W:0]    c;
        logic [3:0]                  cnt;
        logic n1, n2, n3, n4, n5, n6, n7, n8;
        logic side_px, keep, row_ok, col_ok;

        // bit j+1 of each extended line is column of bit j
        ue = {up.nxt[0],  up.cur,  up.prv[bitn_pkg::WORD_W-1]};
        me = {mid.nxt[0], mid.cur, mid.prv[bitn_pkg::WORD_W-1]};
        de = {dn.nxt[0],  dn.cur,  dn.prv[bitn_pkg::WORD_W-1]};

        row_ok = (ctl.row != '0)
              && (({1'b0, ctl.row} + (bitn_pkg::ROW_W+1)'(1)) < ctl.nr);

        for (int j = 0; j < bitn_pkg::WORD_W; j++)
        begin
            c      = {1'b0, ctl.word, bitn_pkg::BIT_W'(j)};
            col_ok = (c != '0) && ((c + (bitn_pkg::COL_W+1)'(1)) < ctl.nc);

            n3 = ue[j];   n2 = ue[j+1]; n1 = ue[j+2];
            n4 = me[j];                 n8 = me[j+2];
            n5 = de[j];   n6 = de[j+1]; n7 = de[j+2];

            cnt = {3'b0, n1} + {3'b0, n2} + {3'b0, n3} + {3'b0, n4}
                + {3'b0, n5} + {3'b0, n6} + {3'b0, n7} + {3'b0, n8};

            case (ctl.side)
                bitn_pkg::SIDE_N: side_px = n2;
                bitn_pkg::SIDE_S: side_px = n6;
                bitn_pkg::SIDE_E: side_px = n8;
                bitn_pkg::SIDE_W: side_px = n4;
                default:          side_px = 1'b1;
            endcase

            // non-simple patterns: deleting would split or end the stroke
            keep = (n2 && !n4 && !n8 && (n5 || n6 || n7))
                || (n6 && !n4 && !n8 && (n1 || n2 || n3))
                || (n8 && !n2 && !n6 && (n3 || n4 || n5))
                || (n4 && !n2 && !n6 && (n7 || n8 || n1))
                || (n5 && !n4 && !n6)
                || (n7 && !n6 && !n8)
                || (n1 && !n8 && !n2)
                || (n3 && !n2 && !n4);

            del[j] = me[j+1] && row_ok && col_ok && !side_px && (cnt >= 4'd2) && !keep;
        end

        new_word = mid.cur & ~del;
        any_del  = |del;
    end

endmodule

// ===== hdl/binary_image_thinning_top.sv =====
// Top level of the binary image thinning block: channels, config registers,
// sweep sequencer and the two image banks. Depends on bitn_pkg, bitn_if,
// bitn_ram and bitn_kernel.
//
// Usage:
//   in_ch  : one beat per item; mode write stores one pixel, mode read fetches
//            one pixel, mode run thins the stored image until a round deletes
//            nothing. Every item gives exactly one beat on out_ch.
//   out_ch : read_pixel (pixel on a read, else 0) and round_count (rounds of
//            the last run, saturating at 65535).
//   cfg_*  : rows_in_use (index 0) and cols_in_use (index 1), written while
//            the block is idle.
// Write or unused mode: the result beat is registered from the accepted item; a
// read passes through ST_PIX_RD first. A run takes 4 sub-passes per round;
// each sub-pass sweeps the whole store at 3 reads per 32-pixel word; the single
// read port of the source bank sets that pace. One item is in work at a time.
// Reset: empties the result register, sets the region to 256 x 1024 and the
// round count to 0; image contents stay undefined until written, no clearing
// pass. A stalled receiver holds the result beat; in_ch.ready stays low until
// the result register can take the next result.
`timescale 1ns / 1ps

module binary_image_thinning_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bitn_in_if.sink                              in_ch,
    bitn_out_if.source                           out_ch,
    input  logic                                 cfg_we,
    input  logic [bitn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bitn_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int ROW_W  = bitn_pkg::ROW_W;
    localparam int WIDX_W = bitn_pkg::WIDX_W;
    localparam int WORD_W = bitn_pkg::WORD_W;
    localparam int BIT_W  = bitn_pkg::BIT_W;
    localparam int ADDR_W = bitn_pkg::ADDR_W;
    localparam int NR_W   = bitn_pkg::NR_W;
    localparam int NC_W   = bitn_pkg::NC_W;
    localparam int RND_W  = bitn_pkg::RND_W;

    // ---------------- registers ----------------
    bitn_pkg::state_t  state_reg, state_next;
    bitn_pkg::side_t   side_reg, side_next;
    logic [NR_W-1:0]   nr_reg;
    logic [NC_W-1:0]   nc_reg;
    logic              bank_reg, bank_next;        // bank holding current image
    logic              round_chg_reg, round_chg_next;
    logic [RND_W-1:0]  rounds_reg, rounds_next;

    // sweep counters: row, word (one past the end flushes), read phase
    logic [ROW_W-1:0]  swp_row_reg, swp_row_next;
    logic [WIDX_W:0]   swp_word_reg, swp_word_next;
    logic [1:0]        swp_phase_reg, swp_phase_next;

    // read-data stage tags
    logic              d_valid_reg, d_zero_reg, d_last_reg;
    logic [1:0]        d_phase_reg;
    logic [ROW_W-1:0]  d_row_reg;
    logic [WIDX_W:0]   d_word_reg;

    // write-back stage
    logic              e_valid_reg, e_last_reg, e_del_reg;
    logic [ADDR_W-1:0] e_addr_reg;
    logic [WORD_W-1:0] e_word_reg;

    bitn_pkg::line_t   lines_reg [3];              // rows above, at, below
    logic [BIT_W-1:0]  pix_bit_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_pixel_reg, out_pixel_next;
    logic [RND_W-1:0]  out_round_reg, out_round_next;

    // ---------------- combinational ----------------
    logic              in_acc, issue, last_step, word_ok, rr_ok, pass_end, chg_all;
    logic [ROW_W:0]    rr_ext;
    logic [ROW_W-1:0]  rr;
    logic [NR_W-1:0]   nr_eff;
    logic [NC_W-1:0]   nc_eff;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [WORD_W-1:0] rdata0, rdata1, rdata_src, d_data, wdata, wmask;
    logic              we0, we1, pix_we;
    logic [WORD_W-1:0] kern_word;
    logic              kern_del;
    bitn_pkg::kern_ctl_t kctl;
    bitn_pkg::line_t     dn_line;

    assign in_acc = in_ch.valid && in_ch.ready;
    assign pix_we = in_acc && (in_ch.mode == bitn_pkg::MODE_WRITE);

    // region clipped to the store
    assign nr_eff = (nr_reg > NR_W'(bitn_pkg::MAX_ROWS)) ? NR_W'(bitn_pkg::MAX_ROWS) : nr_reg;
    assign nc_eff = (nc_reg > NC_W'(bitn_pkg::MAX_COLS)) ? NC_W'(bitn_pkg::MAX_COLS) : nc_reg;

    // ---- sweep read address: row r-1+phase, word w ----
    assign issue     = (state_reg == bitn_pkg::ST_SWEEP);
    assign rr_ext    = {1'b0, swp_row_reg} + (ROW_W+1)'(swp_phase_reg);
    assign rr_ok     = (rr_ext != '0) && (rr_ext <= (ROW_W+1)'(bitn_pkg::MAX_ROWS));
    assign rr        = ROW_W'(rr_ext - (ROW_W+1)'(1));
    assign word_ok   = (swp_word_reg < (WIDX_W+1)'(bitn_pkg::WORDS));
    assign last_step = (swp_row_reg == ROW_W'(bitn_pkg::MAX_ROWS - 1))
                    && (swp_word_reg == (WIDX_W+1)'(bitn_pkg::WORDS))
                    && (swp_phase_reg == 2'd2);

    assign raddr = issue ? {rr, swp_word_reg[WIDX_W-1:0]}
                         : {in_ch.row, in_ch.col[bitn_pkg::COL_W-1:BIT_W]};

    // ---- write port: sweep results go to the other bank ----
    assign waddr = e_valid_reg ? e_addr_reg : {in_ch.row, in_ch.col[bitn_pkg::COL_W-1:BIT_W]};
    assign wdata = e_valid_reg ? e_word_reg : {WORD_W{in_ch.pixel}};
    assign wmask = e_valid_reg ? {WORD_W{1'b1}} : (WORD_W'(1) << in_ch.col[BIT_W-1:0]);
    assign we0   = (pix_we && !bank_reg) || (e_valid_reg && bank_reg);
    assign we1   = (pix_we && bank_reg)  || (e_valid_reg && !bank_reg);

    bitn_ram #(.DATA_W(WORD_W), .ADDR_W(ADDR_W)) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .wmask (wmask),
        .raddr (raddr),
        .rdata (rdata0)
    );

    bitn_ram #(.DATA_W(WORD_W), .ADDR_W(ADDR_W)) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .wmask (wmask),
        .raddr (raddr),
        .rdata (rdata1)
    );

    assign rdata_src = bank_reg ? rdata1 : rdata0;
    assign d_data    = d_zero_reg ? '0 : rdata_src;

    // ---- kernel runs when the row-below word arrives ----
    assign dn_line = {d_data, lines_reg[2].nxt, lines_reg[2].cur};
    assign kctl    = '{row:  d_row_reg,
                       word: WIDX_W'(d_word_reg - (WIDX_W+1)'(1)),
                       side: side_reg,
                       nr:   nr_eff,
                       nc:   nc_eff};

    bitn_kernel u_kernel (
        .ctl      (kctl),
        .up       (lines_reg[0]),
        .mid      (lines_reg[1]),
        .dn       (dn_line),
        .new_word (kern_word),
        .any_del  (kern_del)
    );

    // last write of a sub-pass
    assign pass_end = e_valid_reg && e_last_reg;
    assign chg_all  = round_chg_reg || (e_valid_reg && e_del_reg);

    // ---------------- FSM: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bitn_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_ch.mode)
                        bitn_pkg::MODE_RUN:  state_next = bitn_pkg::ST_SWEEP;
                        bitn_pkg::MODE_READ: state_next = bitn_pkg::ST_PIX_RD;
                        default:             state_next = bitn_pkg::ST_IDLE;
                    endcase
                end
            end
            bitn_pkg::ST_PIX_RD: state_next = bitn_pkg::ST_IDLE;
            bitn_pkg::ST_SWEEP:
            begin
                if (last_step)
                begin
                    state_next = bitn_pkg::ST_DRAIN;
                end
            end
            bitn_pkg::ST_DRAIN:
            begin
                if (pass_end)
                begin
                    if (side_reg == bitn_pkg::SIDE_W && !chg_all)
                    begin
                        state_next = bitn_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = bitn_pkg::ST_SWEEP;
                    end
                end
            end
            default: state_next = bitn_pkg::ST_IDLE;
        endcase
    end

    // ---------------- FSM: outputs and datapath control ----------------
    always_comb
    begin
        in_ch.ready    = (state_reg == bitn_pkg::ST_IDLE) && (!out_valid_reg || out_ch.ready);
        side_next      = side_reg;
        bank_next      = bank_reg;
        round_chg_next = round_chg_reg;
        rounds_next    = rounds_reg;
        swp_row_next   = swp_row_reg;
        swp_word_next  = swp_word_reg;
        swp_phase_next = swp_phase_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_pixel_next = out_pixel_reg;
        out_round_next = out_round_reg;

        case (state_reg)
            bitn_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_ch.mode)
                        bitn_pkg::MODE_RUN:
                        begin
                            side_next      = bitn_pkg::SIDE_N;
                            round_chg_next = 1'b0;
                            rounds_next    = '0;
                            swp_row_next   = '0;
                            swp_word_next  = '0;
                            swp_phase_next = '0;
                        end
                        bitn_pkg::MODE_READ: ;
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_pixel_next = 1'b0;
                            out_round_next = rounds_reg;
                        end
                    endcase
                end
            end
            bitn_pkg::ST_PIX_RD:
            begin
                out_valid_next = 1'b1;
                out_pixel_next = rdata_src[pix_bit_reg];
                out_round_next = rounds_reg;
            end
            bitn_pkg::ST_SWEEP:
            begin
                round_chg_next = chg_all;
                if (swp_phase_reg == 2'd2)
                begin
                    swp_phase_next = '0;
                    if (swp_word_reg == (WIDX_W+1)'(bitn_pkg::WORDS))
                    begin
                        swp_word_next = '0;
                        swp_row_next  = swp_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        swp_word_next = swp_word_reg + (WIDX_W+1)'(1);
                    end
                end
                else
                begin
                    swp_phase_next = swp_phase_reg + 2'd1;
                end
            end
            bitn_pkg::ST_DRAIN:
            begin
                round_chg_next = chg_all;
                if (pass_end)
                begin
                    bank_next = !bank_reg;
                    if (side_reg == bitn_pkg::SIDE_W)
                    begin
                        rounds_next    = (rounds_reg == '1) ? rounds_reg
                                                            : rounds_reg + RND_W'(1);
                        side_next      = bitn_pkg::SIDE_N;
                        round_chg_next = 1'b0;
                        if (!chg_all)
                        begin
                            out_valid_next = 1'b1;
                            out_pixel_next = 1'b0;
                            out_round_next = rounds_next;
                        end
                    end
                    else
                    begin
                        side_next = bitn_pkg::side_t'(side_reg + 2'd1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.read_pixel  = out_pixel_reg;
    assign out_ch.round_count = out_round_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bitn_pkg::ST_IDLE;
            side_reg      <= bitn_pkg::SIDE_N;
            bank_reg      <= 1'b0;
            round_chg_reg <= 1'b0;
            rounds_reg    <= '0;
            swp_row_reg   <= '0;
            swp_word_reg  <= '0;
            swp_phase_reg <= '0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            nr_reg        <= NR_W'(bitn_pkg::MAX_ROWS);
            nc_reg        <= NC_W'(bitn_pkg::MAX_COLS);
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            bank_reg      <= bank_next;
            round_chg_reg <= round_chg_next;
            rounds_reg    <= rounds_next;
            swp_row_reg   <= swp_row_next;
            swp_word_reg  <= swp_word_next;
            swp_phase_reg <= swp_phase_next;
            d_valid_reg   <= issue;
            e_valid_reg   <= d_valid_reg && (d_phase_reg == 2'd2) && (d_word_reg != '0);
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bitn_pkg::REG_ROWS: nr_reg <= cfg_data[NR_W-1:0];
                    bitn_pkg::REG_COLS: nc_reg <= cfg_data[NC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        d_zero_reg    <= !(rr_ok && word_ok);
        d_last_reg    <= last_step;
        d_phase_reg   <= swp_phase_reg;
        d_row_reg     <= swp_row_reg;
        d_word_reg    <= swp_word_reg;
        e_last_reg    <= d_last_reg;
        e_del_reg     <= kern_del;
        e_addr_reg    <= {d_row_reg, WIDX_W'(d_word_reg - (WIDX_W+1)'(1))};
        e_word_reg    <= kern_word;
        pix_bit_reg   <= in_ch.col[BIT_W-1:0];
        out_pixel_reg <= out_pixel_next;
        out_round_reg <= out_round_next;
        if (d_valid_reg)
        begin
            case (d_phase_reg)
                2'd0: lines_reg[0] <= {d_data, lines_reg[0].nxt, lines_reg[0].cur};
                2'd1: lines_reg[1] <= {d_data, lines_reg[1].nxt, lines_reg[1].cur};
                2'd2: lines_reg[2] <= {d_data, lines_reg[2].nxt, lines_reg[2].cur};
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/bitn_checker.sv =====
// Port-level checks of the thinning block, bound to the top level.
// Depends on bitn_pkg and binary_image_thinning_top.
`timescale 1ns / 1ps

module bitn_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [bitn_pkg::MODE_W-1:0] in_mode,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        out_read_pixel,
    input logic [bitn_pkg::RND_W-1:0]  out_round_count
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_read_pixel)
                                  && $stable(out_round_count))
        else $error("result beat changed while stalled");

    // no new item while a result is blocked
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !(out_valid && !out_ready))
        else $error("item taken while result register full");

    // write gives its beat next cycle, read_pixel 0
    a_write_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_mode == bitn_pkg::MODE_WRITE) |=> out_valid && !out_read_pixel)
        else $error("write result missing");

    // read gives its beat through ST_PIX_RD, not straight away
    a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_mode == bitn_pkg::MODE_READ) |=> !out_valid ##1 out_valid)
        else $error("read result timing wrong");

    // a run gives no beat straight after it is taken, and holds ready low
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_mode == bitn_pkg::MODE_RUN) |=> !out_valid && !in_ready)
        else $error("run finished too early");

endmodule

bind binary_image_thinning_top bitn_checker u_bitn_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_mode         (in_ch.mode),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_read_pixel  (out_ch.read_pixel),
    .out_round_count (out_ch.round_count)
);

// ===== test/results_checker.sv =====
// Result checker for the binary image thinning block: watches the item,
// result and register channels, predicts every result beat and compares.
// Depends on bitn_pkg and bitn_if.
`timescale 1ns / 1ps

module results_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    bitn_in_if                                  in_ch,
    bitn_out_if                                 out_ch,
    input  logic                                cfg_we,
    input  logic [bitn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bitn_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  errors,
    output int                                  outstanding
);
    import bitn_pkg::*;

    typedef struct {
        bit               px;
        logic [RND_W-1:0] rounds;
    } pixel_result_t;

    bit               image [MAX_ROWS][MAX_COLS];
    bit               snap  [MAX_ROWS][MAX_COLS];
    logic [NR_W-1:0]  rows_cfg = 9'd256;
    logic [NC_W-1:0]  cols_cfg = 11'd1024;
    logic [RND_W-1:0] last_rounds = '0;
    pixel_result_t    pending_results[$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    // one directional sub-pass; decisions read the snapshot
    function automatic bit thin_side(side_t side, int nr, int nc);
        bit changed;
        bit n1, n2, n3, n4, n5, n6, n7, n8, keep;
        int dr, dc, cnt;
        changed = 0;
        dr = (side == SIDE_N) ? -1 : (side == SIDE_S) ? 1 : 0;
        dc = (side == SIDE_E) ? 1 : (side == SIDE_W) ? -1 : 0;
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                snap[r][c] = image[r][c];
        for (int r = 1; r + 1 < nr; r++)
        begin
            for (int c = 1; c + 1 < nc; c++)
            begin
                if (!snap[r][c] || snap[r+dr][c+dc])
                    continue;
                n3 = snap[r-1][c-1]; n2 = snap[r-1][c]; n1 = snap[r-1][c+1];
                n4 = snap[r][c-1];                      n8 = snap[r][c+1];
                n5 = snap[r+1][c-1]; n6 = snap[r+1][c]; n7 = snap[r+1][c+1];
                cnt = n1 + n2 + n3 + n4 + n5 + n6 + n7 + n8;
                if (cnt <= 1)
                    continue;
                // non-simple patterns: deleting would split or shorten a line
                keep = (n2 && !n4 && !n8 && (n5 | n6 | n7))
                    || (n6 && !n4 && !n8 && (n1 | n2 | n3))
                    || (n8 && !n2 && !n6 && (n3 | n4 | n5))
                    || (n4 && !n2 && !n6 && (n7 | n8 | n1))
                    || (n5 && !n4 && !n6)
                    || (n7 && !n6 && !n8)
                    || (n1 && !n8 && !n2)
                    || (n3 && !n2 && !n4);
                if (!keep)
                begin
                    image[r][c] = 0;
                    changed = 1;
                end
            end
        end
        return changed;
    endfunction

    function automatic logic [RND_W-1:0] thin_image();
        int nr, nc;
        bit changed;
        logic [RND_W-1:0] rounds;
        nr = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
        nc = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
        rounds = '0;
        do
        begin
            changed = 0;
            if (nr >= 3 && nc >= 3)
            begin
                changed |= thin_side(SIDE_N, nr, nc);
                changed |= thin_side(SIDE_S, nr, nc);
                changed |= thin_side(SIDE_E, nr, nc);
                changed |= thin_side(SIDE_W, nr, nc);
            end
            if (rounds != 16'hFFFF)
                rounds++;
        end
        while (changed);
        return rounds;
    endfunction

    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ROWS)
                    rows_cfg = cfg_data[NR_W-1:0];
                else if (cfg_index == REG_COLS)
                    cols_cfg = cfg_data[NC_W-1:0];
            end
            if (in_ch.valid && in_ch.ready)
            begin
                want.px = 0;
                if (in_ch.mode == MODE_WRITE)
                    image[in_ch.row][in_ch.col] = in_ch.pixel;
                else if (in_ch.mode == MODE_RUN)
                    last_rounds = thin_image();
                else if (in_ch.mode == MODE_READ)
                    want.px = image[in_ch.row][in_ch.col];
                want.rounds = last_rounds;
                pending_results.push_back(want);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result beat with nothing expected", $realtime);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.read_pixel !== want.px || out_ch.round_count !== want.rounds)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch pixel %0b/%0b rounds %0d/%0d (exp/act)",
                                     $realtime, want.px, out_ch.read_pixel,
                                     want.rounds, out_ch.round_count);
                    end
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the thinning block testbench: clock, reset, register writes and item
// stimulus; results_checker does prediction and comparison.
// Depends on bitn_pkg, bitn_if, results_checker and the block itself.
`timescale 1ns / 1ps

module testbench;
    import bitn_pkg::*;

    // unused mode code: block only echoes the round count
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  steady = 0;     // no idling on either side while set
    int                    errors;
    int                    outstanding;
    int                    written_addrs[$]; // row*MAX_COLS+col of every written pixel

    bitn_in_if  in_ch ();
    bitn_out_if out_ch ();

    binary_image_thinning_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    results_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // receiver stalls about 14% of cycles, never during the steady stretch
    always @(negedge clk)
        out_ch.ready <= steady || ($urandom_range(99) >= 14);

    initial
    begin
        in_ch.valid  = 0;
        in_ch.mode   = MODE_WRITE;
        in_ch.row    = '0;
        in_ch.col    = '0;
        in_ch.pixel  = 0;
        out_ch.ready = 0;
    end

    // one item beat; gaps go in front, valid held until accepted
    task automatic send(logic [MODE_W-1:0] mode, int r, int c, bit px);
        while (!steady && $urandom_range(99) < 14)
        begin
            in_ch.valid <= 0;
            @(negedge clk);
        end
        in_ch.valid <= 1;
        in_ch.mode  <= mode;
        in_ch.row   <= r[ROW_W-1:0];
        in_ch.col   <= c[COL_W-1:0];
        in_ch.pixel <= px;
        if (mode == MODE_WRITE)
            written_addrs.push_back(r * MAX_COLS + c);
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    // block is idle once every beat has come back
    task automatic drain();
        in_ch.valid <= 0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_region(int rows, int cols);
        cfg_we    <= 1;
        cfg_index <= REG_ROWS;
        cfg_data  <= rows[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_index <= REG_COLS;
        cfg_data  <= cols[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic read_written();
        int a;
        a = written_addrs[$urandom_range(written_addrs.size() - 1)];
        send(MODE_READ, a / MAX_COLS, a % MAX_COLS, $urandom_range(1));
    endtask

    initial
    begin
        int nr, nc, dens, pick;
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: corners of the store, unused mode, empty region run
        send(MODE_SPARE, 0, 0, 0);
        send(MODE_WRITE, 0, 0, 1);
        send(MODE_WRITE, 255, 1023, 1);
        send(MODE_WRITE, 255, 0, 0);
        send(MODE_WRITE, 0, 1023, 0);
        send(MODE_READ, 255, 1023, 0);
        send(MODE_READ, 0, 0, 1);
        send(MODE_READ, 255, 0, 1);
        send(MODE_READ, 0, 1023, 0);
        send(MODE_SPARE, 255, 1023, 1);
        drain();
        // region with no rows at all: one round, nothing deleted
        set_region(0, 0);
        send(MODE_RUN, 0, 0, 0);
        send(MODE_SPARE, 170, 341, 1);
        drain();
        // oversize values clamp to the store; no run here, too costly
        set_region(511, 2047);
        send(MODE_READ, 255, 1023, 0);
        drain();

        // random phases: fill region, mix, thin, read back
        for (int ph = 0; ph < 3; ph++)
        begin
            steady = (ph == 1);
            nr   = (ph == 0) ? 3 : $urandom_range(4, 12);
            nc   = (ph == 0) ? 3 : $urandom_range(4, 24);
            dens = $urandom_range(30, 80);
            set_region(nr, nc);
            for (int r = 0; r < nr; r++)
                for (int c = 0; c < nc; c++)
                    send(MODE_WRITE, r, c, $urandom_range(99) < dens);
            repeat (190)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    send(MODE_WRITE, $urandom_range(nr - 1), $urandom_range(nc - 1),
                         $urandom_range(99) < dens);
                else if (pick < 42)
                    send(MODE_WRITE, $urandom_range(255), $urandom_range(1023),
                         $urandom_range(1));
                else if (pick < 90)
                    read_written();
                else
                    send(MODE_SPARE, $urandom_range(255), $urandom_range(1023),
                         $urandom_range(1));
            end
            send(MODE_RUN, $urandom_range(255), $urandom_range(1023), $urandom_range(1));
            for (int r = 0; r < nr; r++)
                for (int c = 0; c < nc; c++)
                    send(MODE_READ, r, c, 0);
            drain();
        end
        steady = 0;

        repeat (20) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // runs sweep the whole store in every round
    initial
    begin
        #400_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bitn_pkg.sv
hdl/bitn_if.sv
hdl/bitn_ram.sv
hdl/bitn_kernel.sv
hdl/binary_image_thinning_top.sv
hdl/bitn_checker.sv
test/results_checker.sv
test/testbench.sv
